>>> src/bbc_pkg.sv
// Package for the binary/BCD converter: word and digit sizes, function codes,
// controller states and the per-digit helpers of the shift datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bbc_pkg;

  // Word and digit geometry
  localparam int WORD_W     = 32;
  localparam int NIB_W      = 4;
  localparam int NIBS       = WORD_W / NIB_W;
  localparam int DIGITS     = 8;
  // A word holds at most eight nibbles; clamp the digit count to 1..8
  localparam int EFF_DIGITS = (DIGITS > NIBS) ? NIBS : ((DIGITS < 1) ? 1 : DIGITS);
  localparam int CNT_W      = $clog2(WORD_W);
  // Left shift that puts the top used digit into the top nibble
  localparam int FB_SHIFT   = NIB_W * (NIBS - EFF_DIGITS);

  // Function codes carried on the input tuser
  localparam logic FUNC_TO_BCD   = 1'b0;
  localparam logic FUNC_FROM_BCD = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TO_BCD,
    ST_FROM_BCD,
    ST_FINISH
  } state_t;

  function automatic logic [63:0] pow10(input int n);
    logic [63:0] p;
    p = 64'd1;
    for (int i = 0; i < n; i++) begin
      p = p * 64'd10;
    end
    return p;
  endfunction

  // Smallest binary value that no longer fits the digit count
  localparam logic [WORD_W:0] BCD_LIMIT = (WORD_W + 1)'(pow10(EFF_DIGITS));

  // Double dabble correction: add three to every digit of five or more
  function automatic logic [WORD_W-1:0] dd_adjust(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] r;
    r = v;
    for (int i = 0; i < NIBS; i++) begin
      if (r[NIB_W*i +: NIB_W] >= 4'd5) begin
        r[NIB_W*i +: NIB_W] = r[NIB_W*i +: NIB_W] + 4'd3;
      end
    end
    return r;
  endfunction

  // Flag a digit above nine in the used nibbles or any nonzero nibble above them
  function automatic logic bcd_invalid(input logic [WORD_W-1:0] v);
    logic bad;
    bad = 1'b0;
    for (int i = 0; i < NIBS; i++) begin
      if (i < EFF_DIGITS) begin
        if (v[NIB_W*i +: NIB_W] > 4'd9) begin
          bad = 1'b1;
        end
      end else if (v[NIB_W*i +: NIB_W] != 4'd0) begin
        bad = 1'b1;
      end
    end
    return bad;
  endfunction

endpackage

`default_nettype wire

>>> src/binary_bcd_converter.sv
// Binary to BCD: the result is built by the 32-step double dabble shift loop
// after the input transaction. BCD to binary: one digit accumulated per cycle.
// A rejected input skips the loop and goes straight to the output register. No
// new input is taken until the previous result is loaded into the output register.
// Synchronous active-high reset empties the controller and the output register.
`timescale 1ns / 1ps
`default_nettype none

// Top level of the converter: stream ports, controller and serial datapath.
// Depends on bbc_pkg.
module binary_bcd_converter (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [31:0] value_in
  input  wire logic        s_axis_tuser,   // [0] func
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [31:0] value_out
  output logic             m_axis_tuser    // [0] error
);

  bbc_pkg::state_t state, state_next;

  logic [bbc_pkg::WORD_W-1:0] src;     // input bits still to be consumed
  logic [bbc_pkg::WORD_W-1:0] res;     // BCD digits or binary accumulator
  logic [bbc_pkg::CNT_W-1:0]  cnt;
  logic                       err;

  logic                       in_fire;
  logic                       out_free;
  logic                       out_load;
  logic                       in_bad;
  logic                       tb_last;
  logic                       fb_last;
  logic [bbc_pkg::WORD_W-1:0] acc_x10;
  logic [bbc_pkg::WORD_W-1:0] res_adj;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign tb_last  = (cnt == bbc_pkg::CNT_W'(bbc_pkg::WORD_W - 1));
  assign fb_last  = (cnt == bbc_pkg::CNT_W'(bbc_pkg::EFF_DIGITS - 1));

  // Check the input range for the selected direction
  always_comb begin
    if (s_axis_tuser == bbc_pkg::FUNC_TO_BCD) begin
      in_bad = ({1'b0, s_axis_tdata} >= bbc_pkg::BCD_LIMIT);
    end else begin
      in_bad = bbc_pkg::bcd_invalid(s_axis_tdata);
    end
  end

  // One decimal digit step: acc * 10 + next digit
  assign acc_x10 = {res[bbc_pkg::WORD_W-4:0], 3'b000}
                 + {res[bbc_pkg::WORD_W-2:0], 1'b0}
                 + {{(bbc_pkg::WORD_W - bbc_pkg::NIB_W){1'b0}},
                    src[bbc_pkg::WORD_W-1 -: bbc_pkg::NIB_W]};

  // Correct the BCD digits before each shift
  assign res_adj = bbc_pkg::dd_adjust(res);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      bbc_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_bad) begin
            state_next = bbc_pkg::ST_FINISH;
          end else if (s_axis_tuser == bbc_pkg::FUNC_TO_BCD) begin
            state_next = bbc_pkg::ST_TO_BCD;
          end else begin
            state_next = bbc_pkg::ST_FROM_BCD;
          end
        end
      end
      bbc_pkg::ST_TO_BCD: begin
        if (tb_last) state_next = bbc_pkg::ST_FINISH;
      end
      bbc_pkg::ST_FROM_BCD: begin
        if (fb_last) state_next = bbc_pkg::ST_FINISH;
      end
      bbc_pkg::ST_FINISH: begin
        if (out_free) state_next = bbc_pkg::ST_IDLE;
      end
      default: state_next = bbc_pkg::ST_IDLE;
    endcase
  end

  // Controller outputs
  always_comb begin
    s_axis_tready = 1'b0;
    out_load      = 1'b0;
    case (state)
      bbc_pkg::ST_IDLE:   s_axis_tready = 1'b1;
      bbc_pkg::ST_FINISH: out_load      = out_free;
      default: begin
        s_axis_tready = 1'b0;
        out_load      = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bbc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Serial datapath: load, then shift one bit or one digit per cycle
  always_ff @(posedge clk) begin
    case (state)
      bbc_pkg::ST_IDLE: begin
        cnt <= '0;
        if (in_fire) begin
          err <= in_bad;
          if (in_bad) begin
            res <= '1;
            src <= s_axis_tdata;
          end else if (s_axis_tuser == bbc_pkg::FUNC_TO_BCD) begin
            res <= '0;
            src <= s_axis_tdata;
          end else begin
            res <= '0;
            src <= s_axis_tdata << bbc_pkg::FB_SHIFT;
          end
        end
      end
      bbc_pkg::ST_TO_BCD: begin
        res <= {res_adj[bbc_pkg::WORD_W-2:0], src[bbc_pkg::WORD_W-1]};
        src <= {src[bbc_pkg::WORD_W-2:0], 1'b0};
        cnt <= cnt + 1'b1;
      end
      bbc_pkg::ST_FROM_BCD: begin
        res <= acc_x10;
        src <= {src[bbc_pkg::WORD_W-bbc_pkg::NIB_W-1:0], {bbc_pkg::NIB_W{1'b0}}};
        cnt <= cnt + 1'b1;
      end
      default: begin
        cnt <= cnt;
      end
    endcase
  end

  // Output register: hold a result until the downstream side takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= res;
      m_axis_tuser <= err;
    end
  end

endmodule

`default_nettype wire

>>> src/bbc_checker.sv
// Port-level checks for the binary/BCD converter, bound to its top level.
// Depends on binary_bcd_converter only through its ports.
`timescale 1ns / 1ps
`default_nettype none

module bbc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata,
  input wire logic        m_axis_tuser
);

  // A flagged result always carries all ones
  a_err_all_ones: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == 32'hFFFF_FFFF))
    else $error("error result without all-ones data");

  // One conversion at a time: a taken transaction closes the input side
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while a conversion runs");

  // No result appears in the cycle right after a transaction is taken
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && !m_axis_tvalid) |=> !m_axis_tvalid)
    else $error("result too early after input");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("result changed while stalled");

endmodule

bind binary_bcd_converter bbc_checker u_bbc_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
